// ===== design/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared constants for the barometric pressure and temperature compensation
// datapath: calibration register indexes, reference points and output limits.
// ----------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int RAW_W       = 24;
  localparam int PRES_W      = 17;
  localparam int TEMP_W      = 15;

  // calibration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_SENSITIVITY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_OFFSET      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SENS_TEMP_COEFF      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_TEMP_COEFF    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REFERENCE_TEMP       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_COEFF           = 3'd5;

  localparam int TEMP_REF    = 2000;
  localparam int TEMP_LOW_OF = 3500;   // distance from TEMP_REF down to -15.00 C
  localparam int TEMP_MIN    = -4000;
  localparam int TEMP_MAX    = 8500;
  localparam int PRES_MIN    = 1000;
  localparam int PRES_MAX    = 120000;

endpackage

`default_nettype wire

// ===== design/baro_pressure_temp_compensation_unit.sv =====
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation_unit
// Second-order temperature compensation of raw pressure and temperature
// conversions into 0.01 mbar and 0.01 degC, saturated to the rated ranges.
//
// A result strobes on done when its start transaction leaves the output stage.
// Throughput: one transaction per cycle; busy is always low, every stage is
// a plain register so one item per cycle flows through the multiplier stages.
// Reset clears the calibration registers to zero and empties the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module baro_pressure_temp_compensation_unit
  import bpc_pkg::*;
#(
  parameter int ADC_BITS = 24
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [RAW_W-1:0]      raw_pressure,
  input  wire logic [RAW_W-1:0]      raw_temperature,
  output logic                       done,
  output logic [PRES_W-1:0]          pressure_out,
  output logic signed [TEMP_W-1:0]   temperature_out,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data
);

  localparam logic [RAW_W-1:0] ADC_MASK = RAW_W'((33'd1 << ADC_BITS) - 33'd1);

  // calibration registers
  logic [CFG_W-1:0] pressure_sensitivity;
  logic [CFG_W-1:0] pressure_offset;
  logic [CFG_W-1:0] sens_temp_coeff;
  logic [CFG_W-1:0] offset_temp_coeff;
  logic [CFG_W-1:0] reference_temp;
  logic [CFG_W-1:0] temp_coeff;

  always_ff @(posedge clk) begin
    if (rst) begin
      pressure_sensitivity <= '0;
      pressure_offset      <= '0;
      sens_temp_coeff      <= '0;
      offset_temp_coeff    <= '0;
      reference_temp       <= '0;
      temp_coeff           <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_PRESSURE_SENSITIVITY: pressure_sensitivity <= cfg_data;
        CFG_PRESSURE_OFFSET:      pressure_offset      <= cfg_data;
        CFG_SENS_TEMP_COEFF:      sens_temp_coeff      <= cfg_data;
        CFG_OFFSET_TEMP_COEFF:    offset_temp_coeff    <= cfg_data;
        CFG_REFERENCE_TEMP:       reference_temp       <= cfg_data;
        CFG_TEMP_COEFF:           temp_coeff           <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // stage valid bits
  logic [6:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[5:0], start};
      done <= vld[6];
    end
  end

  // stage 1: mask inputs, dT
  logic [RAW_W-1:0]   d1_1;
  logic signed [24:0] dt1;

  always_ff @(posedge clk) begin
    d1_1 <= raw_pressure & ADC_MASK;
    dt1  <= $signed({1'b0, raw_temperature & ADC_MASK}) -
            $signed({1'b0, reference_temp, 8'd0});
  end

  // stage 2: products with dT
  logic [RAW_W-1:0]   d1_2;
  logic signed [40:0] p6;
  logic signed [40:0] p4;
  logic signed [40:0] p3;
  logic signed [49:0] sq;

  always_ff @(posedge clk) begin
    d1_2 <= d1_1;
    p6   <= 41'(dt1) * 41'($signed({1'b0, temp_coeff}));
    p4   <= 41'(dt1) * 41'($signed({1'b0, offset_temp_coeff}));
    p3   <= 41'(dt1) * 41'($signed({1'b0, sens_temp_coeff}));
    sq   <= 50'(dt1) * 50'(dt1);
  end

  // stage 3: first-order terms
  logic [RAW_W-1:0]   d1_3;
  logic signed [17:0] d3;
  logic [16:0]        t2_3;
  logic signed [39:0] off1_3;
  logic signed [39:0] sens1_3;

  always_ff @(posedge clk) begin
    d1_3    <= d1_2;
    d3      <= p6[40:23];
    t2_3    <= sq[47:31];
    off1_3  <= $signed({8'd0, pressure_offset, 16'd0}) + {{6{p4[40]}}, p4[40:7]};
    sens1_3 <= $signed({9'd0, pressure_sensitivity, 15'd0}) + {{7{p3[40]}}, p3[40:8]};
  end

  // stage 4: squares for the second-order terms, temperature
  logic signed [18:0] e3;
  logic signed [35:0] f_prod;
  logic signed [37:0] g_prod;
  logic               neg3;
  logic signed [19:0] temp4_next;

  assign e3     = {d3[17], d3} + 19'(TEMP_LOW_OF);
  assign f_prod = 36'(d3) * 36'(d3);
  assign g_prod = 38'(e3) * 38'(e3);
  assign neg3   = d3[17];
  assign temp4_next = 20'(TEMP_REF) + 20'(d3) -
                      (neg3 ? $signed({3'd0, t2_3}) : 20'sd0);

  logic [RAW_W-1:0]   d1_4;
  logic [34:0]        f4;
  logic [34:0]        g4;
  logic               neg4;
  logic               low4;
  logic signed [19:0] temp4;
  logic signed [39:0] off1_4;
  logic signed [39:0] sens1_4;

  always_ff @(posedge clk) begin
    d1_4    <= d1_3;
    f4      <= f_prod[34:0];
    g4      <= g_prod[34:0];
    neg4    <= neg3;
    low4    <= e3[18];
    temp4   <= temp4_next;
    off1_4  <= off1_3;
    sens1_4 <= sens1_3;
  end

  // stage 5: second-order offset and sensitivity
  logic [36:0] f5x;
  logic [37:0] g7x;
  logic [37:0] g11x;
  logic [37:0] off2;
  logic [36:0] sens2;

  assign f5x   = {f4, 2'b00} + 37'(f4);
  assign g7x   = {g4, 3'b000} - 38'(g4);
  assign g11x  = {g4, 3'b000} + 38'({g4, 1'b0}) + 38'(g4);
  assign off2  = 38'(f5x[36:1]) + (low4 ? g7x : 38'd0);
  assign sens2 = 37'(f5x[36:2]) + (low4 ? g11x[37:1] : 37'd0);

  logic [RAW_W-1:0]   d1_5;
  logic signed [39:0] off5;
  logic signed [39:0] sens5;
  logic signed [19:0] temp5;

  always_ff @(posedge clk) begin
    d1_5  <= d1_4;
    off5  <= off1_4 - (neg4 ? $signed({2'd0, off2}) : 40'sd0);
    sens5 <= sens1_4 - (neg4 ? $signed({3'd0, sens2}) : 40'sd0);
    temp5 <= temp4;
  end

  // stage 6: D1 * SENS as two partial products
  logic [43:0]        plo;
  logic signed [44:0] phi;
  logic signed [39:0] off6;
  logic signed [19:0] temp6;

  always_ff @(posedge clk) begin
    plo   <= 44'(d1_5) * 44'(sens5[19:0]);
    phi   <= 45'($signed({1'b0, d1_5})) * 45'($signed(sens5[39:20]));
    off6  <= off5;
    temp6 <= temp5;
  end

  // stage 7: combine partial products
  logic signed [63:0] prod7;
  logic signed [39:0] off7;
  logic signed [19:0] temp7;

  always_ff @(posedge clk) begin
    prod7 <= $signed({phi[43:0], 20'd0}) + $signed({20'd0, plo});
    off7  <= off6;
    temp7 <= temp6;
  end

  // output stage: pressure and saturation
  logic signed [43:0] pdiff;
  logic signed [28:0] pres;

  assign pdiff = {prod7[63], prod7[63:21]} - {{4{off7[39]}}, off7};
  assign pres  = pdiff[43:15];

  always_ff @(posedge clk) begin
    priority if (pres < PRES_MIN) begin
      pressure_out <= PRES_W'(PRES_MIN);
    end else if (pres > PRES_MAX) begin
      pressure_out <= PRES_W'(PRES_MAX);
    end else begin
      pressure_out <= pres[PRES_W-1:0];
    end
    priority if (temp7 < TEMP_MIN) begin
      temperature_out <= TEMP_W'(TEMP_MIN);
    end else if (temp7 > TEMP_MAX) begin
      temperature_out <= TEMP_W'(TEMP_MAX);
    end else begin
      temperature_out <= temp7[TEMP_W-1:0];
    end
  end

  // every accepted transaction yields one result after the full pipe
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##8 done)
    else $error("result missing after start transaction");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(vld[6]))
    else $error("result without a matching transaction");

  a_pres_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (pressure_out >= PRES_W'(PRES_MIN) && pressure_out <= PRES_W'(PRES_MAX)))
    else $error("pressure out of rated range");

  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (temperature_out >= TEMP_W'(TEMP_MIN) &&
              temperature_out <= TEMP_W'(TEMP_MAX)))
    else $error("temperature out of rated range");

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Regression for baro_pressure_temp_compensation_unit. Directed conversion
// pairs at reset, all-ones and typical calibration hit the field extremes,
// the 20.00 C and -15.00 C correction boundaries and both saturation limits.
// Random phases follow, each after the first with new calibration words. A scoreboard
// predicts every compensated reading and checks each done strobe in order.
// ----------------------------------------------------------------------------

import bpc_pkg::*;

typedef struct packed {
  logic [PRES_W-1:0]        pressure;
  logic signed [TEMP_W-1:0] temperature;
} reading_t;

class compensation_board;
  bit [CFG_W-1:0] cal [0:5];
  reading_t expected_readings [$];
  int failures;

  function new();
    foreach (cal[i]) cal[i] = '0;
    failures = 0;
  endfunction

  function void set_calibration(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    if (idx <= CFG_TEMP_COEFF) cal[idx] = data;
  endfunction

  function reading_t compensate(logic [RAW_W-1:0] p_raw, logic [RAW_W-1:0] t_raw);
    longint d1, d2, dt, temp, off, sens, pres;
    longint t2, dev, dev_sq, off2, sens2, cold_dev, cold_sq;
    reading_t r;
    d1 = p_raw;
    d2 = t_raw;
    dt = d2 - longint'(cal[CFG_REFERENCE_TEMP]) * 256;
    temp = TEMP_REF + ((dt * longint'(cal[CFG_TEMP_COEFF])) >>> 23);
    off = longint'(cal[CFG_PRESSURE_OFFSET]) * 65536
        + ((longint'(cal[CFG_OFFSET_TEMP_COEFF]) * dt) >>> 7);
    sens = longint'(cal[CFG_PRESSURE_SENSITIVITY]) * 32768
         + ((longint'(cal[CFG_SENS_TEMP_COEFF]) * dt) >>> 8);
    // second-order correction below 20.00 C, extra term below -15.00 C
    if (temp < TEMP_REF) begin
      t2 = (dt * dt) >>> 31;
      dev = temp - TEMP_REF;
      dev_sq = dev * dev;
      off2 = (5 * dev_sq) >>> 1;
      sens2 = (5 * dev_sq) >>> 2;
      if (temp < TEMP_REF - TEMP_LOW_OF) begin
        cold_dev = temp - (TEMP_REF - TEMP_LOW_OF);
        cold_sq = cold_dev * cold_dev;
        off2 += 7 * cold_sq;
        sens2 += (11 * cold_sq) >>> 1;
      end
      temp -= t2;
      off -= off2;
      sens -= sens2;
    end
    pres = (((d1 * sens) >>> 21) - off) >>> 15;
    if (pres < PRES_MIN) pres = PRES_MIN;
    else if (pres > PRES_MAX) pres = PRES_MAX;
    if (temp < TEMP_MIN) temp = TEMP_MIN;
    else if (temp > TEMP_MAX) temp = TEMP_MAX;
    r.pressure = pres[PRES_W-1:0];
    r.temperature = temp[TEMP_W-1:0];
    return r;
  endfunction

  function void note_reading(logic [RAW_W-1:0] p_raw, logic [RAW_W-1:0] t_raw);
    expected_readings.push_back(compensate(p_raw, t_raw));
  endfunction

  function void check_reading(logic [PRES_W-1:0] p, logic signed [TEMP_W-1:0] t);
    reading_t want;
    if (expected_readings.size() == 0) begin
      $error("unexpected result: pressure_out %0d, temperature_out %0d", p, t);
      failures++;
      return;
    end
    want = expected_readings.pop_front();
    if (p !== want.pressure) begin
      $error("pressure_out: expected %0d, got %0d", want.pressure, p);
      failures++;
    end
    if (t !== want.temperature) begin
      $error("temperature_out: expected %0d, got %0d", want.temperature, t);
      failures++;
    end
  endfunction

  function int outstanding();
    return expected_readings.size();
  endfunction
endclass

module testbench;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic [RAW_W-1:0]         raw_pressure = '0;
  logic [RAW_W-1:0]         raw_temperature = '0;
  logic                     done;
  logic [PRES_W-1:0]        pressure_out;
  logic signed [TEMP_W-1:0] temperature_out;
  logic                     cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_W-1:0]         cfg_data = '0;

  bit [CFG_W-1:0] cal_words [0:5];
  compensation_board board = new();

  baro_pressure_temp_compensation_unit uut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .raw_pressure   (raw_pressure),
    .raw_temperature(raw_temperature),
    .done           (done),
    .pressure_out   (pressure_out),
    .temperature_out(temperature_out),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_wr_en) board.set_calibration(cfg_index, cfg_data);
      if (start && !busy) board.note_reading(raw_pressure, raw_temperature);
      if (done) board.check_reading(pressure_out, temperature_out);
    end
  end

  function automatic int pick_gap(input bit gapless);
    int roll;
    roll = $urandom_range(0, 99);
    if (gapless || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_reading(input logic [RAW_W-1:0] p, input logic [RAW_W-1:0] t,
                              input int gap);
    start <= 1'b1;
    raw_pressure <= p;
    raw_temperature <= t;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      raw_pressure <= RAW_W'($urandom);
      raw_temperature <= RAW_W'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle_pipeline();
    start <= 1'b0;
    @(posedge clk);
    while (board.outstanding() != 0) @(posedge clk);
  endtask

  // spare indexes get random data and must leave the calibration alone
  task automatic load_calibration();
    for (int i = 0; i < (1 << CFG_IDX_W); i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      if (i <= CFG_TEMP_COEFF) cfg_data <= cal_words[i];
      else cfg_data <= CFG_W'($urandom);
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
  endtask

  // temperature conversions mostly cluster around the reference point
  task automatic draw_reading(output logic [RAW_W-1:0] p, output logic [RAW_W-1:0] t);
    longint probe;
    int span;
    if ($urandom_range(0, 1)) p = RAW_W'($urandom);
    else p = RAW_W'($urandom_range(6_000_000, 10_000_000));
    if ($urandom_range(0, 3) == 0) begin
      t = RAW_W'($urandom);
    end else begin
      span = $urandom_range(4, 22);
      probe = $urandom_range(0, (1 << span) - 1);
      if ($urandom_range(0, 1)) probe = -probe;
      probe += longint'(cal_words[CFG_REFERENCE_TEMP]) * 256;
      if (probe < 0) probe = 0;
      else if (probe > (longint'(1) << RAW_W) - 1) probe = (longint'(1) << RAW_W) - 1;
      t = probe[RAW_W-1:0];
    end
  endtask

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [RAW_W-1:0] p, t;
    bit gapless;
    int pick;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // calibration still at reset
    send_reading('0, '0, pick_gap(1'b0));
    send_reading('1, '1, pick_gap(1'b0));

    settle_pipeline();
    foreach (cal_words[i]) cal_words[i] = '1;
    load_calibration();
    send_reading('0, '0, pick_gap(1'b0));
    send_reading('1, '1, pick_gap(1'b0));
    send_reading('1, '0, pick_gap(1'b0));
    send_reading('0, '1, pick_gap(1'b0));
    send_reading(24'd9085466, 24'd16776960, pick_gap(1'b0));
    send_reading(24'd9085466, 24'd16776959, pick_gap(1'b0));
    send_reading('1, 24'd16776960, pick_gap(1'b0));

    settle_pipeline();
    cal_words = '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312};
    load_calibration();
    send_reading(24'd9085466, 24'd8569150, pick_gap(1'b0));
    send_reading('0, 24'd8569150, pick_gap(1'b0));
    send_reading('1, 24'd8569150, pick_gap(1'b0));
    send_reading(24'd9085466, '0, pick_gap(1'b0));
    send_reading(24'd9085466, '1, pick_gap(1'b0));
    // exactly 20.00 C and one step below
    send_reading(24'd9085466, 24'd8566784, pick_gap(1'b0));
    send_reading(24'd9085466, 24'd8566783, pick_gap(1'b0));
    // exactly -15.00 C and one step below
    send_reading(24'd9085466, 24'd7529764, pick_gap(1'b0));
    send_reading(24'd9085466, 24'd7529763, pick_gap(1'b0));
    send_reading('1, '0, pick_gap(1'b0));
    send_reading('0, '0, pick_gap(1'b0));
    send_reading('0, '1, pick_gap(1'b0));
    send_reading('1, '1, pick_gap(1'b0));

    for (int ph = 0; ph < 8; ph++) begin
      settle_pipeline();
      if (ph > 0) begin
        foreach (cal_words[i]) begin
          pick = $urandom_range(0, 5);
          if (pick == 0) cal_words[i] = '0;
          else if (pick == 1) cal_words[i] = '1;
          else cal_words[i] = CFG_W'($urandom);
        end
        load_calibration();
      end
      gapless = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < 119; n++) begin
        draw_reading(p, t);
        send_reading(p, t, pick_gap(gapless));
        if ($urandom_range(0, 79) == 0) settle_pipeline();
      end
    end

    settle_pipeline();
    repeat (16) @(posedge clk);
    if (board.outstanding() != 0) begin
      $error("%0d results never arrived", board.outstanding());
      board.failures++;
    end
    if (board.failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/bpc_pkg.sv
design/baro_pressure_temp_compensation_unit.sv
sim/testbench.sv
